// ----- rtl/eed_pkg.sv -----
// ----------------------------------------------------------------------------
// eed_pkg
// Shared types and character codes for the echo escape decoder.
// ----------------------------------------------------------------------------
package eed_pkg;

    // Largest number of result words one input word can cause
    localparam int unsigned RunMax = 3;

    // Decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_OCTAL  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_V  = 8'h76;

    // Upper five bits shared by the octal digits '0' to '7'
    localparam logic [4:0] OCT_HIGH = 5'b00110;

    // Result words caused by one input word, oldest in entry 0
    typedef struct packed {
        logic [RunMax-1:0][7:0] bytes;
        logic [1:0]             count;
    } t_eed_run;

endpackage

// ----- rtl/eed_decode.sv -----
// ----------------------------------------------------------------------------
// eed_decode
// Escape decoder state and the single-pass decode of one input word into
// up to three result bytes.
// ----------------------------------------------------------------------------
module eed_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_newline_enable,
    input  logic [7:0]       i_data_byte,
    input  logic             i_has_byte,
    input  logic             i_arg_end,
    input  logic             i_final_arg,
    output eed_pkg::t_eed_run o_run
);
    import eed_pkg::*;

    logic [1:0] r_mode,    n_mode;
    logic [8:0] r_oct_val, n_oct_val;
    logic [1:0] r_oct_cnt, n_oct_cnt;
    logic       r_stopped, n_stopped;

    // Append one byte to a run, drop it when the run is full
    function automatic t_eed_run put_byte(t_eed_run run, logic [7:0] c);
        t_eed_run res;
        res = run;
        if (run.count != 2'(RunMax)) begin
            res.bytes[run.count] = c;
            res.count = run.count + 2'd1;
        end
        return res;
    endfunction

    // Decode the presented word against the current state
    always_comb begin
        t_eed_run   run;
        logic [8:0] oct_next;
        logic [1:0] cnt_next;
        run       = '0;
        n_mode    = r_mode;
        n_oct_val = r_oct_val;
        n_oct_cnt = r_oct_cnt;
        n_stopped = r_stopped;
        oct_next  = {r_oct_val[5:0], i_data_byte[2:0]};
        cnt_next  = r_oct_cnt + 2'd1;

        if (!r_stopped && i_has_byte) begin
            if (r_mode == MODE_ESCAPE) begin
                n_mode = MODE_NORMAL;
                case (i_data_byte)
                    CH_LC_A: run = put_byte(run, CH_BEL);
                    CH_LC_B: run = put_byte(run, CH_BS);
                    CH_LC_F: run = put_byte(run, CH_FF);
                    CH_LC_N: run = put_byte(run, CH_LF);
                    CH_LC_R: run = put_byte(run, CH_CR);
                    CH_LC_T: run = put_byte(run, CH_TAB);
                    CH_LC_V: run = put_byte(run, CH_VT);
                    CH_BSL:  run = put_byte(run, CH_BSL);
                    CH_LC_C: n_stopped = 1'b1;
                    CH_ZERO: begin
                        n_mode    = MODE_OCTAL;
                        n_oct_val = '0;
                        n_oct_cnt = '0;
                    end
                    default: begin
                        run = put_byte(run, CH_BSL);
                        run = put_byte(run, i_data_byte);
                    end
                endcase
            end else if (r_mode == MODE_OCTAL) begin
                if (i_data_byte[7:3] == OCT_HIGH) begin
                    // Gather a digit, emit on the third
                    n_oct_val = oct_next;
                    n_oct_cnt = cnt_next;
                    if (cnt_next == 2'd3) begin
                        run       = put_byte(run, oct_next[7:0]);
                        n_mode    = MODE_NORMAL;
                        n_oct_val = '0;
                        n_oct_cnt = '0;
                    end
                end else begin
                    // Cut short: emit the value, then decode as plain text
                    run       = put_byte(run, r_oct_val[7:0]);
                    n_mode    = MODE_NORMAL;
                    n_oct_val = '0;
                    n_oct_cnt = '0;
                    if (i_data_byte == CH_BSL && !i_arg_end) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        run = put_byte(run, i_data_byte);
                    end
                end
            end else begin
                n_mode = MODE_NORMAL;
                if (i_data_byte == CH_BSL && !i_arg_end) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    run = put_byte(run, i_data_byte);
                end
            end
        end

        // Close the argument: flush pending escape or octal value, add separator or newline
        if (i_arg_end) begin
            if (!n_stopped) begin
                if (n_mode == MODE_ESCAPE) begin
                    run = put_byte(run, CH_BSL);
                end else if (n_mode == MODE_OCTAL) begin
                    run = put_byte(run, n_oct_val[7:0]);
                end
                if (!i_final_arg) begin
                    run = put_byte(run, CH_SPACE);
                end else if (i_newline_enable) begin
                    run = put_byte(run, CH_LF);
                end
            end
            n_mode    = MODE_NORMAL;
            n_oct_val = '0;
            n_oct_cnt = '0;
            if (i_final_arg) begin
                n_stopped = 1'b0;
            end
        end

        o_run = run;
    end

    // Advance the state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_oct_val <= '0;
            r_oct_cnt <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_oct_val <= n_oct_val;
            r_oct_cnt <= n_oct_cnt;
            r_stopped <= n_stopped;
        end
    end

endmodule

// ----- rtl/eed_result_fifo.sv -----
// ----------------------------------------------------------------------------
// eed_result_fifo
// Result buffer: takes a run of up to three bytes per cycle while not full, gives
// one byte per cycle unless stalled, and marks the last byte of each run.
// ----------------------------------------------------------------------------
module eed_result_fifo #(
    parameter int unsigned ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  eed_pkg::t_eed_run i_run,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_byte,
    output logic              o_last
);
    import eed_pkg::*;

    localparam int unsigned Depth = 1 << ADDR_W;

    logic [8:0]        r_mem [Depth];
    logic [ADDR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ADDR_W:0]   r_count,  n_count;
    logic              pop;
    logic [ADDR_W:0]   push_cnt;

    assign pop      = (r_count != '0) && !i_stall;
    assign push_cnt = i_push ? (ADDR_W+1)'(i_run.count) : '0;

    // Hold off input unless a whole run fits
    assign o_full  = r_count > (ADDR_W+1)'(Depth - RunMax);
    assign o_valid = r_count != '0;
    assign o_byte  = r_mem[r_rd_ptr][7:0];
    assign o_last  = r_mem[r_rd_ptr][8];

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_cnt[ADDR_W-1:0];
        n_rd_ptr = r_rd_ptr + ADDR_W'(pop);
        n_count  = r_count + push_cnt - (ADDR_W+1)'(pop);
    end

    // Write the run's bytes at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RunMax; k++) begin
            if (i_push && (2'(k) < i_run.count)) begin
                r_mem[r_wr_ptr + ADDR_W'(k)] <= {(2'(k + 1) == i_run.count),
                                                 i_run.bytes[k]};
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/echo_escape_decoder_core.sv -----
// ----------------------------------------------------------------------------
// echo_escape_decoder_core
// Backslash escape decoder for echo-style argument streams.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   data_byte has_byte arg_end
//                                                 final_arg
//   output   out        o_out_valid / i_out_stall out_byte last_of_run
//   config   in         i_cfg_we                  i_cfg_wdata (newline_enable)
//
// An input word is decoded in the cycle it is accepted; its bytes can leave
// from the result buffer on the next cycle, one byte per cycle unless stalled.
// A word is taken every cycle while the buffer has room for three bytes, so
// the sustained rate is set by the one-byte-per-cycle output port.
// Reset is synchronous and clears the decoder state and buffer; newline
// append comes up enabled. An output stall fills the buffer, then stalls input.
// ----------------------------------------------------------------------------
module echo_escape_decoder_core #(
    parameter int unsigned FIFO_ADDR_W = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_arg_end,
    input  logic       i_final_arg,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);
    import eed_pkg::*;

    logic     r_newline_en;
    logic     accept;
    logic     full;
    t_eed_run run;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // Hold the newline enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newline_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_newline_en <= i_cfg_wdata;
        end
    end

    // Decode one word per cycle while the buffer has room
    eed_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_newline_enable (r_newline_en),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_arg_end        (i_arg_end),
        .i_final_arg      (i_final_arg),
        .o_run            (run)
    );

    // Buffer the resulting bytes
    eed_result_fifo #(
        .ADDR_W (FIFO_ADDR_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_run   (run),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_byte  (o_out_byte),
        .o_last  (o_last_of_run)
    );

endmodule
